### rtl/core/mclp_pkg.sv
// Types, character codes and helper functions shared by the command line parser.
`default_nettype none

package mclp_pkg;

  typedef enum logic [1:0] {
    CMD_FORWARD  = 2'd0,
    CMD_BACKWARD = 2'd1,
    CMD_STOP     = 2'd2,
    CMD_STEER    = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    NUM_SKIP   = 2'd0,
    NUM_DIGITS = 2'd1,
    NUM_DONE   = 2'd2
  } num_phase_t;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_PLUS  = 2'd1,
    DIR_MINUS = 2'd2
  } dir_t;

  typedef struct packed {
    command_t           command;
    logic signed [15:0] left_speed;
    logic               left_forward;
    logic signed [15:0] right_speed;
    logic               right_forward;
  } res_t;

  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_COMMA = 8'd44;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;
  localparam logic [7:0] CHAR_S     = 8'd115;
  localparam logic [7:0] CHAR_T     = 8'd116;
  localparam logic [7:0] CHAR_W     = 8'd119;
  localparam logic [7:0] CHAR_X     = 8'd120;

  localparam logic [9:0]         DRIVE_SPEED_RST = 10'd400;
  localparam logic [16:0]        NUM_CAP         = 17'd32768;
  localparam logic signed [15:0] SPEED_MAX       = 16'sd32767;
  localparam logic [2:0]         COMMA_MAX       = 3'd4;
  localparam logic [1:0]         LINE_CNT_MAX    = 2'd2;

  // Signed value of a parsed number, clamped to the 16-bit range.
  function automatic logic signed [15:0] num_value(input logic neg, input logic [16:0] mag);
    logic [16:0] neg_mag;
    neg_mag = 17'd0 - mag;
    if (neg) begin
      return signed'(neg_mag[15:0]);
    end
    if (mag > 17'(SPEED_MAX)) begin
      return SPEED_MAX;
    end
    return signed'(mag[15:0]);
  endfunction

  function automatic dir_t dir_class(input logic signed [15:0] v);
    if (v == 16'sd1) begin
      return DIR_PLUS;
    end
    if (v == -16'sd1) begin
      return DIR_MINUS;
    end
    return DIR_NONE;
  endfunction

endpackage

`default_nettype wire

### rtl/core/mclp_if.sv
// Channel interfaces: received bytes, speed configuration and motor commands.
`default_nettype none

interface mclp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mclp_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] drive_speed;

  modport source (output valid, output drive_speed, input ready);
  modport sink   (input valid, input drive_speed, output ready);
endinterface

interface mclp_out_if import mclp_pkg::*; ();
  logic               valid;
  logic               ready;
  command_t           command;
  logic signed [15:0] left_speed;
  logic               left_forward;
  logic signed [15:0] right_speed;
  logic               right_forward;

  modport source (output valid, output command, output left_speed, output left_forward,
                  output right_speed, output right_forward, input ready);
  modport sink   (input valid, input command, input left_speed, input left_forward,
                  input right_speed, input right_forward, output ready);
endinterface

`default_nettype wire

### rtl/core/mclp_in_reg.sv
// Input register: holds one received byte until the parse stage takes it.
`default_nettype none

module mclp_in_reg (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_rx_byte,
  output logic            in_ready,
  input  wire logic       adv,
  output logic            byte_vld,
  output logic [7:0]      byte_data
);

  logic       vld_r;
  logic [7:0] data_r;

  assign in_ready  = rst_n & (~vld_r | adv);
  assign byte_vld  = vld_r;
  assign byte_data = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      data_r <= in_rx_byte;
    end
  end

endmodule

`default_nettype wire

### rtl/core/mclp_parser.sv
// Line parser: per-byte line state, number parse and command decode on newline.
`default_nettype none

module mclp_parser import mclp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [9:0] cfg_drive_speed,
  input  wire logic       fire,
  input  wire logic [7:0] c,
  output logic            res_vld,
  output res_t            res
);

  logic [9:0]         drive_speed_r;
  logic [1:0]         line_cnt_r,     line_cnt_nxt;
  logic [7:0]         first_char_r,   first_char_nxt;
  logic               steer_ok_r,     steer_ok_nxt;
  logic [2:0]         comma_cnt_r,    comma_cnt_nxt;
  num_phase_t         num_phase_r,    num_phase_nxt;
  logic               num_neg_r,      num_neg_nxt;
  logic [16:0]        num_mag_r,      num_mag_nxt;
  logic signed [15:0] first_speed_r,  first_speed_nxt;
  dir_t               first_dir_r,    first_dir_nxt;
  logic signed [15:0] second_speed_r, second_speed_nxt;

  logic               is_ws;
  logic               is_digit;
  logic               is_sign;
  logic [19:0]        mag_acc;
  logic [16:0]        mag_sat;
  logic signed [15:0] cur_val;
  dir_t               cur_dir;
  logic [15:0]        drive_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_speed_r <= DRIVE_SPEED_RST;
    end else if (cfg_we) begin
      drive_speed_r <= cfg_drive_speed;
    end
  end

  assign is_ws    = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  assign is_sign  = (c == CHAR_PLUS) || (c == CHAR_MINUS);
  // Digit value is the low nibble for '0'..'9'
  assign mag_acc  = 20'(num_mag_r) * 20'd10 + 20'(c[3:0]);
  assign mag_sat  = (mag_acc > 20'(NUM_CAP)) ? NUM_CAP : mag_acc[16:0];
  assign cur_val  = num_value(num_neg_r, num_mag_r);
  assign cur_dir  = dir_class(cur_val);
  assign drive_ext = 16'(drive_speed_r);

  always_comb begin
    line_cnt_nxt     = line_cnt_r;
    first_char_nxt   = first_char_r;
    steer_ok_nxt     = steer_ok_r;
    comma_cnt_nxt    = comma_cnt_r;
    num_phase_nxt    = num_phase_r;
    num_neg_nxt      = num_neg_r;
    num_mag_nxt      = num_mag_r;
    first_speed_nxt  = first_speed_r;
    first_dir_nxt    = first_dir_r;
    second_speed_nxt = second_speed_r;
    res_vld          = 1'b0;
    res              = '0;

    if (fire) begin
      if (c == CHAR_NL) begin
        if (line_cnt_r == 2'd1) begin
          if ((first_char_r == CHAR_W) || (first_char_r == CHAR_S)) begin
            res_vld           = 1'b1;
            res.command       = (first_char_r == CHAR_W) ? CMD_FORWARD : CMD_BACKWARD;
            res.left_speed    = signed'(drive_ext);
            res.right_speed   = signed'(drive_ext);
            res.left_forward  = (first_char_r == CHAR_W);
            res.right_forward = (first_char_r == CHAR_W);
          end else if (first_char_r == CHAR_X) begin
            res_vld     = 1'b1;
            res.command = CMD_STOP;
          end
        end else if (steer_ok_r && (comma_cnt_r == COMMA_MAX)) begin
          if ((first_dir_r != DIR_NONE) && (cur_dir != DIR_NONE)) begin
            res_vld           = 1'b1;
            res.command       = CMD_STEER;
            res.left_speed    = first_speed_r;
            res.left_forward  = (first_dir_r == DIR_PLUS);
            res.right_speed   = second_speed_r;
            res.right_forward = (cur_dir == DIR_PLUS);
          end
        end
        // Clear all line state
        line_cnt_nxt     = '0;
        first_char_nxt   = '0;
        steer_ok_nxt     = 1'b0;
        comma_cnt_nxt    = '0;
        num_phase_nxt    = NUM_SKIP;
        num_neg_nxt      = 1'b0;
        num_mag_nxt      = '0;
        first_speed_nxt  = '0;
        first_dir_nxt    = DIR_NONE;
        second_speed_nxt = '0;
      end else begin
        if (line_cnt_r == 2'd0) begin
          first_char_nxt = c;
        end else if (line_cnt_r == 2'd1) begin
          steer_ok_nxt = (first_char_r == CHAR_T) && (c == CHAR_COMMA);
        end
        if (line_cnt_r < LINE_CNT_MAX) begin
          line_cnt_nxt = line_cnt_r + 2'd1;
        end

        if ((c == CHAR_COMMA) && (comma_cnt_r < COMMA_MAX)) begin
          case (comma_cnt_r)
            3'd1:    first_speed_nxt  = cur_val;
            3'd2:    first_dir_nxt    = cur_dir;
            3'd3:    second_speed_nxt = cur_val;
            default: ;
          endcase
          comma_cnt_nxt = comma_cnt_r + 3'd1;
          num_phase_nxt = NUM_SKIP;
          num_neg_nxt   = 1'b0;
          num_mag_nxt   = '0;
        end else begin
          unique case (num_phase_r)
            NUM_SKIP: begin
              if (is_ws) begin
                num_phase_nxt = NUM_SKIP;
              end else if (is_sign) begin
                num_neg_nxt   = (c == CHAR_MINUS);
                num_phase_nxt = NUM_DIGITS;
              end else if (is_digit) begin
                num_phase_nxt = NUM_DIGITS;
                num_mag_nxt   = mag_sat;
              end else begin
                num_phase_nxt = NUM_DONE;
              end
            end
            NUM_DIGITS: begin
              if (is_digit) begin
                num_mag_nxt = mag_sat;
              end else begin
                num_phase_nxt = NUM_DONE;
              end
            end
            NUM_DONE: num_phase_nxt = NUM_DONE;
            default:  num_phase_nxt = NUM_DONE;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_cnt_r     <= '0;
      first_char_r   <= '0;
      steer_ok_r     <= 1'b0;
      comma_cnt_r    <= '0;
      num_phase_r    <= NUM_SKIP;
      num_neg_r      <= 1'b0;
      num_mag_r      <= '0;
      first_speed_r  <= '0;
      first_dir_r    <= DIR_NONE;
      second_speed_r <= '0;
    end else begin
      line_cnt_r     <= line_cnt_nxt;
      first_char_r   <= first_char_nxt;
      steer_ok_r     <= steer_ok_nxt;
      comma_cnt_r    <= comma_cnt_nxt;
      num_phase_r    <= num_phase_nxt;
      num_neg_r      <= num_neg_nxt;
      num_mag_r      <= num_mag_nxt;
      first_speed_r  <= first_speed_nxt;
      first_dir_r    <= first_dir_nxt;
      second_speed_r <= second_speed_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/mclp_out_reg.sv
// Result register: holds one command word until the downstream side takes it.
`default_nettype none

module mclp_out_reg import mclp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic res_vld,
  input  res_t      res,
  output logic      adv,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_res
);

  logic vld_r;
  res_t res_r;

  // Free when empty or when the held word leaves this cycle
  assign adv       = ~vld_r | out_ready;
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_vld) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

### rtl/core/motor_command_line_parser.sv
// Motor command line parser: one received byte per cycle in, at most one motor command word
// out per newline. A byte is registered on acceptance in the input register, parsed by a single
// combinational stage (one multiply by ten and add for the number field) when it leaves that
// register, and the resulting command is registered in the result register for the output
// channel. The input takes a byte every cycle while the result register is free or
// draining; it stalls only while a command word waits on a deasserted out_if.ready. The drive
// speed register accepts writes every cycle out of reset and should be changed only while no
// line is being parsed.
`default_nettype none

module motor_command_line_parser import mclp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  mclp_in_if.sink   in_if,
  mclp_cfg_if.sink  cfg_if,
  mclp_out_if.source out_if
);

  logic       adv;
  logic       byte_vld;
  logic [7:0] byte_data;
  logic       fire;
  logic       res_vld;
  res_t       res;
  res_t       out_res;

  assign cfg_if.ready = rst_n;
  assign fire         = byte_vld & adv;

  mclp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_rx_byte (in_if.rx_byte),
    .in_ready   (in_if.ready),
    .adv        (adv),
    .byte_vld   (byte_vld),
    .byte_data  (byte_data)
  );

  mclp_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_if.valid & cfg_if.ready),
    .cfg_drive_speed (cfg_if.drive_speed),
    .fire            (fire),
    .c               (byte_data),
    .res_vld         (res_vld),
    .res             (res)
  );

  mclp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (res_vld),
    .res       (res),
    .adv       (adv),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_res   (out_res)
  );

  assign out_if.command       = out_res.command;
  assign out_if.left_speed    = out_res.left_speed;
  assign out_if.left_forward  = out_res.left_forward;
  assign out_if.right_speed   = out_res.right_speed;
  assign out_if.right_forward = out_res.right_forward;

endmodule

`default_nettype wire

### rtl/core/mclp_checker.sv
// Port-level checks for the motor command line parser, bound to the top level.
`default_nettype none

module mclp_checker import mclp_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic [7:0]         in_rx_byte,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [1:0]         out_command,
  input wire logic signed [15:0] out_left_speed,
  input wire logic               out_left_forward,
  input wire logic signed [15:0] out_right_speed,
  input wire logic               out_right_forward
);

  // A fresh command follows an accepted newline through the input and result registers
  a_result_after_newline: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && (in_rx_byte == CHAR_NL), 2))
    else $error("command word not preceded by an accepted newline");

  a_drive_symmetric: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_command == CMD_FORWARD) || (out_command == CMD_BACKWARD))) |->
      ((out_left_speed == out_right_speed) && (out_left_speed[15:10] == 6'd0) &&
       (out_left_forward == out_right_forward) &&
       (out_left_forward == (out_command == CMD_FORWARD))))
    else $error("drive command with mismatched wheels");

  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_command == CMD_STOP)) |->
      ((out_left_speed == 16'sd0) && (out_right_speed == 16'sd0) &&
       !out_left_forward && !out_right_forward))
    else $error("stop command with non-zero fields");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_command) && $stable(out_left_speed) &&
       $stable(out_right_speed)))
    else $error("stalled command word changed");

endmodule

bind motor_command_line_parser mclp_checker u_mclp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_if.valid),
  .in_ready          (in_if.ready),
  .in_rx_byte        (in_if.rx_byte),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_command       (out_if.command),
  .out_left_speed    (out_if.left_speed),
  .out_left_forward  (out_if.left_forward),
  .out_right_speed   (out_if.right_speed),
  .out_right_forward (out_if.right_forward)
);

`default_nettype wire
